@@ rtl/core/msplit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msplit_pkg;

    localparam int unsigned LEN_W        = 6;
    localparam int unsigned TOT_W        = 7;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned REG_BYTES    = 48;
    localparam int unsigned BIDX_W       = 6;
    localparam int unsigned NUM_BND_REGS = 6;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 64;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_4 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_5 = 3'd6;

    typedef logic [REG_BYTES-1:0][7:0] t_bnd;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        logic               block_end;
        logic               last_block;
        logic               input_error;
        logic [COUNT_W-1:0] bytes_in_block;
    } t_out_item;

    typedef struct packed {
        logic       match_next;
        logic       match_last;
        logic [7:0] leaving;
    } t_chain;

endpackage

`default_nettype wire

@@ rtl/core/msplit_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msplit_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic [7:0]                   i_d,
    input  wire logic [msplit_pkg::LEN_W-1:0] i_len,
    input  wire msplit_pkg::t_bnd             i_bnd,
    input  wire msplit_pkg::t_chain           i_chain,
    output logic [7:0]                        o_q,
    output msplit_pkg::t_chain                o_chain
);

    localparam logic [msplit_pkg::TOT_W-1:0] POS = msplit_pkg::TOT_W'(IDX);

    logic [7:0]                   r_q;
    logic [msplit_pkg::TOT_W-1:0] w_len;
    logic [msplit_pkg::TOT_W-1:0] w_k;
    logic [7:0]                   w_bnd_byte;
    logic                         w_care;
    logic [7:0]                   w_exp_next;
    logic [7:0]                   w_exp_last;
    logic                         w_is_oldest;

    assign w_len       = {1'b0, i_len};
    assign w_k         = w_len + 7'd1 - POS;
    assign w_bnd_byte  = (w_k < msplit_pkg::TOT_W'(msplit_pkg::REG_BYTES))
                       ? i_bnd[w_k[msplit_pkg::BIDX_W-1:0]] : 8'h00;
    assign w_is_oldest = (POS == w_len + 7'd3);

    always_comb begin
        w_care     = 1'b1;
        w_exp_next = msplit_pkg::CHAR_CR;
        w_exp_last = msplit_pkg::CHAR_CR;
        if (POS > w_len + 7'd3) begin
            w_care = 1'b0;
        end else if (POS == w_len + 7'd3) begin
            w_exp_next = msplit_pkg::CHAR_CR;
            w_exp_last = msplit_pkg::CHAR_CR;
        end else if (POS == w_len + 7'd2) begin
            w_exp_next = msplit_pkg::CHAR_LF;
            w_exp_last = msplit_pkg::CHAR_LF;
        end else if (POS >= 7'd2) begin
            w_exp_next = w_bnd_byte;
            w_exp_last = w_bnd_byte;
        end else if (POS == 7'd1) begin
            w_exp_next = msplit_pkg::CHAR_CR;
            w_exp_last = msplit_pkg::CHAR_DASH;
        end else begin
            w_exp_next = msplit_pkg::CHAR_LF;
            w_exp_last = msplit_pkg::CHAR_DASH;
        end
    end

    assign o_chain.match_next = i_chain.match_next && (!w_care || (i_d == w_exp_next));
    assign o_chain.match_last = i_chain.match_last && (!w_care || (i_d == w_exp_last));
    assign o_chain.leaving    = i_chain.leaving | (w_is_oldest ? r_q : 8'h00);
    assign o_q                = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= 8'h00;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/msplit_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msplit_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire msplit_pkg::t_out_item i_item,
    output logic                       o_full,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output msplit_pkg::t_out_item      o_item
);

    logic                  r_out_valid;
    logic                  r_skid_valid;
    msplit_pkg::t_out_item r_out_item;
    msplit_pkg::t_out_item r_skid_item;
    logic                  w_take;

    assign w_take  = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_item <= r_skid_item;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                r_out_item <= i_item;
            end else begin
                r_skid_item <= i_item;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while the output register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("item pushed while both buffer stages are full");

endmodule

`default_nettype wire

@@ rtl/core/multipart_boundary_splitter_core.sv @@
// Splits a multipart body into blocks, one byte per clock. Every accepted item
// (a byte, or an end-of-input mark) is handled in the cycle it is accepted and
// its result, if any, is pushed into the output buffer; a sustained rate of one
// item per cycle is kept as long as the output side takes results. The byte
// window is a row of MAX_BOUNDARY_BYTES+4 cells that shift once per byte; the
// cells the delimiter spans compare their new byte against both forms of the
// delimiter, and the match and the released byte travel along the row in the
// same cycle. A two-entry output buffer sits behind the row, and o_in_stall
// rises only while both entries are full. Configuration writes are always
// accepted (o_cfg_ready is tied high) and take effect on the next item.
`timescale 1ns / 1ps
`default_nettype none

module multipart_boundary_splitter_core #(
    parameter int unsigned MAX_BOUNDARY_BYTES = 48
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire msplit_pkg::t_in_item              i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output msplit_pkg::t_out_item                  o_out_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [msplit_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [msplit_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned DEPTH   = MAX_BOUNDARY_BYTES + 4;
    localparam int unsigned LEN_CAP = (MAX_BOUNDARY_BYTES > 63) ? 63 : MAX_BOUNDARY_BYTES;

    logic [msplit_pkg::LEN_W-1:0]                                    r_len;
    logic [msplit_pkg::NUM_BND_REGS-1:0][msplit_pkg::CFG_DATA_W-1:0] r_bnd;
    logic [msplit_pkg::COUNT_W-1:0]                                  r_cnt;
    logic [msplit_pkg::COUNT_W-1:0]                                  n_cnt;

    msplit_pkg::t_bnd               w_bnd;
    logic [msplit_pkg::LEN_W-1:0]   w_len;
    logic [msplit_pkg::TOT_W-1:0]   w_tot;
    logic                           w_acc;
    logic                           w_eoi;
    logic                           w_shift;
    logic [msplit_pkg::COUNT_W-1:0] w_cnt_inc;
    logic                           w_over;
    logic                           w_hit_next;
    logic                           w_hit_last;
    logic                           w_push;
    logic                           w_full;
    msplit_pkg::t_out_item          w_res;
    msplit_pkg::t_chain             w_chain [0:DEPTH];
    logic [7:0]                     w_q     [0:DEPTH-1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_bnd <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                msplit_pkg::CFG_LENGTH:  begin
                    r_len <= i_cfg_data[msplit_pkg::LEN_W-1:0];
                end
                msplit_pkg::CFG_BYTES_0: begin
                    r_bnd[0] <= i_cfg_data;
                end
                msplit_pkg::CFG_BYTES_1: begin
                    r_bnd[1] <= i_cfg_data;
                end
                msplit_pkg::CFG_BYTES_2: begin
                    r_bnd[2] <= i_cfg_data;
                end
                msplit_pkg::CFG_BYTES_3: begin
                    r_bnd[3] <= i_cfg_data;
                end
                msplit_pkg::CFG_BYTES_4: begin
                    r_bnd[4] <= i_cfg_data;
                end
                msplit_pkg::CFG_BYTES_5: begin
                    r_bnd[5] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_bnd = r_bnd;
    assign w_len = (r_len > msplit_pkg::LEN_W'(LEN_CAP)) ? msplit_pkg::LEN_W'(LEN_CAP) : r_len;
    assign w_tot = {1'b0, w_len} + 7'd4;

    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_eoi   = i_in_item.end_of_input;
    assign w_shift = w_acc && !w_eoi;

    assign w_chain[0].match_next = 1'b1;
    assign w_chain[0].match_last = 1'b1;
    assign w_chain[0].leaving    = 8'h00;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        msplit_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     ((g == 0) ? i_in_item.in_byte : w_q[(g == 0) ? 0 : g - 1]),
            .i_len   (w_len),
            .i_bnd   (w_bnd),
            .i_chain (w_chain[g]),
            .o_q     (w_q[g]),
            .o_chain (w_chain[g+1])
        );
    end

    assign w_cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
    assign w_over     = w_cnt_inc > msplit_pkg::COUNT_W'(w_tot);
    assign w_hit_next = w_chain[DEPTH].match_next;
    assign w_hit_last = !w_hit_next && w_chain[DEPTH].match_last;
    assign w_push     = w_acc && (w_eoi || w_over);

    always_comb begin
        w_res = '0;
        if (w_eoi) begin
            w_res.input_error    = 1'b1;
            w_res.bytes_in_block = r_cnt;
        end else begin
            w_res.data_valid     = 1'b1;
            w_res.data_byte      = w_chain[DEPTH].leaving;
            w_res.block_end      = w_hit_next || w_hit_last;
            w_res.last_block     = w_hit_last;
            w_res.bytes_in_block = (w_hit_next || w_hit_last) ? w_cnt_inc : '0;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_acc) begin
            if (w_eoi) begin
                n_cnt = '0;
            end else if (w_over && (w_hit_next || w_hit_last)) begin
                n_cnt = '0;
            end else begin
                n_cnt = w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    msplit_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    assign o_in_stall = w_full;

    a_eoi_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_eoi |=> r_cnt == '0)
        else $error("count not cleared after end of input");

    a_block_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_res.block_end |=> r_cnt == '0)
        else $error("count not cleared after block end");

    a_short_block_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift && !w_over |=> r_cnt == $past(w_cnt_inc))
        else $error("count lost a byte inside a short block");

endmodule

`default_nettype wire

@@ tb/multipart_boundary_splitter_checker.sv @@
`timescale 1ns / 1ps

module multipart_boundary_splitter_checker
    import msplit_pkg::*;
#(
    parameter int unsigned MAX_BOUNDARY_BYTES = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire t_in_item               i_in_item,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire t_out_item              i_out_item,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int unsigned WIN_DEPTH = MAX_BOUNDARY_BYTES + 4;

    logic [LEN_W-1:0]            bnd_len;
    logic [CFG_DATA_W-1:0]       bnd_regs [NUM_BND_REGS];
    logic [WIN_DEPTH-1:0][7:0]   byte_window;
    logic [COUNT_W-1:0]          block_bytes;
    t_out_item                   released_items [$];

    function automatic int unsigned eff_len();
        return (bnd_len > MAX_BOUNDARY_BYTES) ? MAX_BOUNDARY_BYTES : int'(bnd_len);
    endfunction

    function automatic logic [7:0] delim_byte(input int unsigned p, input int unsigned tot,
                                              input logic closing);
        int unsigned k;
        k = p - 2;
        if (p == 0)
            return CHAR_CR;
        if (p == 1)
            return CHAR_LF;
        if (p + 2 < tot)
            return (k >= REG_BYTES) ? 8'h00 : bnd_regs[k >> 3][(k & 7) * 8 +: 8];
        if (closing)
            return CHAR_DASH;
        return (p + 2 == tot) ? CHAR_CR : CHAR_LF;
    endfunction

    function automatic logic window_matches(input int unsigned tot, input logic closing);
        int unsigned p;
        for (p = 0; p < tot; p++) begin
            if (byte_window[tot - 1 - p] != delim_byte(p, tot, closing))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic split_step(input t_in_item it);
        int unsigned        tot;
        logic [7:0]         leaving;
        logic [COUNT_W-1:0] cnt;
        logic               nxt;
        logic               fin;
        t_out_item          res;
        tot = eff_len() + 4;
        res = '0;
        if (it.end_of_input) begin
            res.input_error    = 1'b1;
            res.bytes_in_block = block_bytes;
            block_bytes        = '0;
            released_items.push_back(res);
            return;
        end
        leaving     = byte_window[tot - 1];
        byte_window = {byte_window[WIN_DEPTH-2:0], it.in_byte};
        cnt         = (block_bytes == '1) ? block_bytes : block_bytes + 1'b1;
        block_bytes = cnt;
        if (cnt <= tot)
            return;
        nxt = window_matches(tot, 1'b0);
        fin = !nxt && window_matches(tot, 1'b1);
        res.data_valid = 1'b1;
        res.data_byte  = leaving;
        res.block_end  = nxt || fin;
        res.last_block = fin;
        if (nxt || fin) begin
            res.bytes_in_block = cnt;
            block_bytes        = '0;
        end
        released_items.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            bnd_len      = '0;
            foreach (bnd_regs[r])
                bnd_regs[r] = '0;
            byte_window  = '0;
            block_bytes  = '0;
            released_items.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LENGTH)
                    bnd_len = i_cfg_data[LEN_W-1:0];
                else if (i_cfg_index >= CFG_BYTES_0 && i_cfg_index <= CFG_BYTES_5)
                    bnd_regs[i_cfg_index - CFG_BYTES_0] = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (released_items.size() == 0) begin
                    $error("result with nothing expected: %0h", i_out_item);
                    o_fail_count++;
                end else begin
                    want = released_items.pop_front();
                    check_field("data_valid", want.data_valid, i_out_item.data_valid);
                    check_field("data_byte", want.data_byte, i_out_item.data_byte);
                    check_field("block_end", want.block_end, i_out_item.block_end);
                    check_field("last_block", want.last_block, i_out_item.last_block);
                    check_field("input_error", want.input_error, i_out_item.input_error);
                    check_field("bytes_in_block", want.bytes_in_block,
                                i_out_item.bytes_in_block);
                end
            end
            if (i_in_valid && !i_in_stall)
                split_step(i_in_item);
        end
        o_pending <= released_items.size();
    end

endmodule

@@ tb/tb_multipart_boundary_splitter_core.sv @@
`timescale 1ns / 1ps

module tb_multipart_boundary_splitter_core;
    import msplit_pkg::*;

    localparam int unsigned MAX_BND         = 48;
    localparam int unsigned RANDOM_ITEMS    = 960;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT  = 3000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int unsigned BND_RANDOM = 0;
    localparam int unsigned BND_TRICKY = 1;
    localparam int unsigned BND_ZERO   = 2;
    localparam int unsigned BND_ONES   = 3;

    localparam int unsigned PHASE_LEN [PHASES] = '{1, 63, 5, 48, 0, 12, 2, 40, 7, 55, 3, 9};
    localparam int unsigned PHASE_MODE [PHASES] = '{
        BND_RANDOM, BND_TRICKY, BND_ZERO, BND_ONES,
        BND_RANDOM, BND_TRICKY, BND_ZERO, BND_ONES,
        BND_RANDOM, BND_TRICKY, BND_ZERO, BND_TRICKY
    };

    typedef logic [7:0] t_byte_q [$];

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req = 1'b0;

    logic [7:0]  cur_bnd [REG_BYTES];
    int unsigned cur_eff;

    always #5 i_clk = ~i_clk;

    multipart_boundary_splitter_core #(
        .MAX_BOUNDARY_BYTES(MAX_BND)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    multipart_boundary_splitter_checker #(
        .MAX_BOUNDARY_BYTES(MAX_BND)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_boundary(input int unsigned len, input int unsigned mode);
        logic [CFG_DATA_W-1:0] word;
        int unsigned           r;
        int unsigned           k;
        cur_eff = (len > MAX_BND) ? MAX_BND : len;
        for (k = 0; k < REG_BYTES; k++) begin
            if (k >= cur_eff) begin
                cur_bnd[k] = 8'($urandom_range(255));
            end else begin
                case (mode)
                    BND_TRICKY: begin
                        case ($urandom_range(4))
                            0: cur_bnd[k] = CHAR_CR;
                            1: cur_bnd[k] = CHAR_LF;
                            2: cur_bnd[k] = CHAR_DASH;
                            3: cur_bnd[k] = 8'h00;
                            default: cur_bnd[k] = 8'($urandom_range(255));
                        endcase
                    end
                    BND_ZERO: cur_bnd[k] = 8'h00;
                    BND_ONES: cur_bnd[k] = 8'hFF;
                    default: cur_bnd[k] = 8'($urandom_range(255));
                endcase
            end
        end
        write_reg(CFG_LENGTH, CFG_DATA_W'(len));
        for (r = 0; r < NUM_BND_REGS; r++) begin
            for (k = 0; k < 8; k++)
                word[8*k +: 8] = cur_bnd[8*r + k];
            write_reg(CFG_BYTES_0 + CFG_IDX_W'(r), word);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_seq(input t_byte_q seq);
        foreach (seq[k])
            send_item('{in_byte: seq[k], end_of_input: 1'b0});
    endtask

    task automatic send_end();
        send_item('{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(9))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CHAR_DASH;
            3: return cur_bnd[$urandom_range(REG_BYTES - 1)];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_byte_q delimiter(input logic closing);
        t_byte_q     d;
        int unsigned k;
        d = {CHAR_CR, CHAR_LF};
        for (k = 0; k < cur_eff; k++)
            d.push_back(cur_bnd[k]);
        if (closing) begin
            d.push_back(CHAR_DASH);
            d.push_back(CHAR_DASH);
        end else begin
            d.push_back(CHAR_CR);
            d.push_back(CHAR_LF);
        end
        return d;
    endfunction

    task automatic send_block();
        t_byte_q     seq;
        t_byte_q     delim;
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        int unsigned pos;
        seq = {};
        n = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(90, 13);
        for (k = 0; k < n; k++)
            seq.push_back(payload_byte());
        pick = $urandom_range(99);
        if (pick < 80) begin
            delim = delimiter(pick >= 45 && (pick < 65 || $urandom_range(1) == 1));
            if (pick >= 65) begin
                // break the delimiter: cut it short or corrupt one byte
                pos = $urandom_range(delim.size() - 1);
                if ($urandom_range(1) == 1) begin
                    while (delim.size() > pos)
                        void'(delim.pop_back());
                end else begin
                    delim[pos] = delim[pos] ^ 8'($urandom_range(255, 1));
                end
            end
            seq = {seq, delim};
        end
        send_seq(seq);
        if (pick >= 80 && pick < 90)
            send_end();
    endtask

    initial begin
        t_byte_q     seq;
        int unsigned ph;
        int unsigned len;
        int unsigned target;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        send_idle_pct = 14;
        recv_idle_pct = 65;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_SPARE, {$urandom, $urandom});
        load_boundary(0, BND_RANDOM);
        send_end();
        seq = {8'h00, 8'hFF, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF,
               8'h55, CHAR_CR, CHAR_LF, CHAR_DASH, CHAR_DASH,
               CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, 8'hAA};
        send_seq(seq);
        send_end();
        i_in_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 14;
            end else if (ph == 2 * PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            len = (ph == PHASES - 1) ? $urandom_range(63) : PHASE_LEN[ph];
            load_boundary(len, PHASE_MODE[ph]);
            if (ph == 1)
                hold_off_req = 1'b1;
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                send_block();
            i_in_valid <= 1'b0;
        end

        wait_drained();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
